// File: sv/lbfp_pkg.sv
// Package for the LSB-first bit field packer.
// Payload word types, command and error codes, store request struct, FSM states.
// No dependencies.
`default_nettype none
package lbfp_pkg;

  localparam int BUF_BYTES = 256;
  localparam int ADDR_W    = $clog2(BUF_BYTES);

  localparam logic [2:0] CMD_PACK   = 3'd0;
  localparam logic [2:0] CMD_UNPACK = 3'd1;
  localparam logic [2:0] CMD_LOAD   = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_MODE    = 2'd1;
  localparam logic [1:0] ERR_PENDING = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  localparam logic       MODE_PACK   = 1'b0;
  localparam logic       MODE_UNPACK = 1'b1;

  localparam logic       CFG_MODE    = 1'b0;
  localparam logic       CFG_SIZE    = 1'b1;

  localparam logic [8:0] BUF_LIMIT   = 9'(BUF_BYTES);

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] field_value;
    logic [5:0]  field_width;
    logic [7:0]  byte_address;
    logic [7:0]  byte_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [8:0]  bytes_used;
    logic [2:0]  bits_pending;
    logic [1:0]  error_code;
  } out_word_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic logic [31:0] low_mask32(input logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'd1 << n) - 32'd1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: sv/lbfp_store.sv
// Byte store of the packer: one write port, one read port, registered read data.
// Depends on lbfp_pkg.
`default_nettype none
module lbfp_store
  import lbfp_pkg::*;
(
  input  wire logic       clk,
  input  wire store_req_t req,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [BUF_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule
`default_nettype wire

// File: sv/lbfp_seq.sv
// Command sequencer: cursors, partial byte, one byte segment of a field per cycle.
// Depends on lbfp_pkg; drives the lbfp_store request.
`default_nettype none
module lbfp_seq
  import lbfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire in_word_t   in_word,
  input  wire logic       mode,
  input  wire logic [8:0] size,
  input  wire logic [7:0] rd_data,
  output store_req_t      req,
  output logic            busy,
  output logic            out_valid,
  output out_word_t       out_word
);

  state_t      state_r, state_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] val_r, val_nxt;
  logic [5:0]  left_r, left_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [2:0]  bitc_r, bitc_nxt;
  logic [7:0]  partial_r, partial_nxt;
  logic [8:0]  bcur_r, bcur_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic [3:0]  room;
  logic [3:0]  take;
  logic [3:0]  bsum;
  logic [7:0]  mask8;
  logic [7:0]  byte_in;
  logic [7:0]  chunk8;
  logic [5:0]  wclamp;
  logic        in_range;
  logic        finish;

  assign room   = 4'd8 - {1'b0, bitc_r};
  assign take   = (left_r < {2'b00, room}) ? left_r[3:0] : room;
  assign bsum   = {1'b0, bitc_r} + take;
  assign mask8  = 8'((9'd1 << take) - 9'd1);
  assign wclamp = (in_word.field_width > 6'd32) ? 6'd32 : in_word.field_width;
  assign in_range = bcur_r < size;
  assign byte_in  = in_range ? rd_data : 8'd0;
  assign chunk8   = (byte_in >> bitc_r) & mask8;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    bitc_nxt      = bitc_r;
    partial_nxt   = partial_r;
    bcur_nxt      = bcur_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    finish        = 1'b0;
    req.wr_en     = 1'b0;
    req.wr_addr   = bcur_r[ADDR_W-1:0];
    req.wr_data   = partial_r;
    req.rd_addr   = bcur_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_word.command == CMD_READ) begin
          req.rd_addr = in_word.byte_address;
        end
        if (start) begin
          state_nxt = ST_RUN;
          cmd_nxt   = in_word.command;
          val_nxt   = in_word.field_value & low_mask32(wclamp);
          left_nxt  = wclamp;
          pos_nxt   = 6'd0;
          acc_nxt   = 32'd0;
          err_nxt   = ERR_OK;
          addr_nxt  = in_word.byte_address;
          data_nxt  = in_word.byte_data;
        end
      end
      ST_RUN: begin
        case (cmd_r)
          CMD_PACK: begin
            if (mode != MODE_PACK) begin
              err_nxt = ERR_MODE;
              finish  = 1'b1;
            end else if (left_r == 6'd0) begin
              finish = 1'b1;
            end else begin
              partial_nxt = partial_r | 8'((val_r[7:0] & mask8) << bitc_r);
              val_nxt     = val_r >> take;
              left_nxt    = left_r - {2'b00, take};
              bitc_nxt    = bsum[2:0];
              if (bsum == 4'd8) begin
                req.wr_data = partial_nxt;
                if (in_range) begin
                  req.wr_en = 1'b1;
                end else begin
                  err_nxt = ERR_OVERRUN;
                end
                if (bcur_r < BUF_LIMIT + 9'd1) begin
                  bcur_nxt = bcur_r + 9'd1;
                end
                partial_nxt = 8'd0;
                bitc_nxt    = 3'd0;
              end
              finish = (left_nxt == 6'd0);
            end
          end
          CMD_UNPACK: begin
            if (mode != MODE_UNPACK) begin
              err_nxt = ERR_MODE;
              finish  = 1'b1;
            end else if (left_r == 6'd0) begin
              finish = 1'b1;
            end else begin
              if (!in_range) begin
                err_nxt = ERR_OVERRUN;
              end
              acc_nxt  = acc_r | (32'(chunk8) << pos_r[4:0]);
              pos_nxt  = pos_r + {2'b00, take};
              left_nxt = left_r - {2'b00, take};
              bitc_nxt = bsum[2:0];
              if (bsum == 4'd8) begin
                bitc_nxt = 3'd0;
                if (bcur_r < BUF_LIMIT + 9'd1) begin
                  bcur_nxt = bcur_r + 9'd1;
                end
              end
              req.rd_addr = bcur_nxt[ADDR_W-1:0];
              finish = (left_nxt == 6'd0);
            end
          end
          CMD_LOAD: begin
            req.wr_addr = addr_r;
            req.wr_data = data_r;
            if ({1'b0, addr_r} < size) begin
              req.wr_en = 1'b1;
            end else begin
              err_nxt = ERR_OVERRUN;
            end
            finish = 1'b1;
          end
          CMD_READ: begin
            if ({1'b0, addr_r} < size) begin
              acc_nxt = {24'd0, rd_data};
            end else begin
              err_nxt = ERR_OVERRUN;
            end
            finish = 1'b1;
          end
          CMD_RESET: begin
            if (bitc_r != 3'd0 || partial_r != 8'd0) begin
              err_nxt = ERR_PENDING;
            end else if (bcur_r > size) begin
              err_nxt = ERR_OVERRUN;
            end
            bitc_nxt    = 3'd0;
            partial_nxt = 8'd0;
            bcur_nxt    = 9'd0;
            finish      = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_nxt                 = ST_IDLE;
          out_valid_nxt             = 1'b1;
          out_word_nxt.result_value = acc_nxt;
          out_word_nxt.bytes_used   = bcur_nxt;
          out_word_nxt.bits_pending = bitc_nxt;
          out_word_nxt.error_code   = err_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bitc_r      <= 3'd0;
      partial_r   <= 8'd0;
      bcur_r      <= 9'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bitc_r      <= bitc_nxt;
      partial_r   <= partial_nxt;
      bcur_r      <= bcur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    left_r     <= left_nxt;
    pos_r      <= pos_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_strobe_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_RUN && state_r == ST_IDLE)
    else $error("result strobe without a finished command");

  a_cursor_sat: assert property (@(posedge clk) disable iff (!rst_n)
    bcur_r <= BUF_LIMIT + 9'd1)
    else $error("byte cursor beyond saturation");

  a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> state_r == ST_RUN && (cmd_r == CMD_PACK || cmd_r == CMD_LOAD))
    else $error("store write outside pack or load");

  a_write_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> {1'b0, req.wr_addr} < size)
    else $error("store write past buffer size");

  a_pending_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cmd_r == CMD_RESET) |=> bitc_r == 3'd0 && bcur_r == 9'd0)
    else $error("cursor not cleared by reset command");

endmodule
`default_nettype wire

// File: sv/lsb_first_bit_field_packer.sv
// Top level of the LSB-first bit field packer: configuration registers, store, sequencer.
// Depends on lbfp_pkg, lbfp_store and lbfp_seq.
//
//   channel  ports                           handshake
//   input    start, busy, in_word            taken when start & !busy
//   result   out_strobe, out_word            one cycle, cannot be held off
//   config   cfg_we, cfg_index, cfg_data     written when cfg_we
//
// A command is accepted, then runs: pack and unpack handle one byte segment of the
// field per cycle (1 to 5 segments); every other command, and a zero width field,
// finishes without a segment step. Unpack reads the store one segment ahead
// through its registered read port. Synchronous reset clears the cursors and
// configuration; the store is not cleared. No result stall.
`default_nettype none
module lsb_first_bit_field_packer
  import lbfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_word_t   in_word,
  output logic            out_strobe,
  output out_word_t       out_word,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data
);

  logic       mode_r;
  logic [8:0] bsize_r;
  logic [8:0] size;
  store_req_t req;
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PACK;
      bsize_r <= BUF_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r  <= cfg_data[0];
        CFG_SIZE: bsize_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign size = (bsize_r > BUF_LIMIT) ? BUF_LIMIT : bsize_r;

  lbfp_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  lbfp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .mode      (mode_r),
    .size      (size),
    .rd_data   (rd_data),
    .req       (req),
    .busy      (busy),
    .out_valid (out_strobe),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
